>>> design/i2c_rtc_register_slave_core_assert.svh
// Assertion macros for the RTC register slave checker.
// Used by irs_checker; needs nothing else.
`ifndef I2C_RTC_REGISTER_SLAVE_CORE_ASSERT_SVH
`define I2C_RTC_REGISTER_SLAVE_CORE_ASSERT_SVH

// consequent checked in the next cycle
`define IRS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("irs check failed");

// same cycle
`define IRS_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("irs check failed");

`endif

>>> design/irs_pkg.sv
// Types, constants and helper functions for the RTC register slave.
// No dependencies.
package irs_pkg;

   typedef enum logic [1:0] {
      MODE_START = 2'd0,
      MODE_STOP  = 2'd1,
      MODE_WRITE = 2'd2,
      MODE_READ  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_READ   = 2'd1,
      PH_CURSOR = 2'd2,
      PH_WRITE  = 2'd3
   } phase_type;

   localparam logic [6:0] DEV_ADDR = 7'h68;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 12;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHIP_TYPE  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EPOCH_YEAR = 1'b1;

   localparam logic [1:0]  CHIP_TYPE_RESET  = 2'd0;
   localparam logic [11:0] EPOCH_YEAR_RESET = 12'd1970;

   localparam logic [1:0] CHIP_BASE    = 2'd0;
   localparam logic [1:0] CHIP_COMPACT = 2'd1;

   // cursor limit per chip type, before clamping to the store size
   localparam logic [7:0] LIMIT_TABLE [4] = '{8'h3f, 8'h12, 8'hff, 8'hff};
   localparam logic [7:0] BASE_MASK       = 8'h3f;

   localparam logic [7:0] READ_IDLE_BYTE = 8'hff;

   // snapshot sequence steps
   localparam logic [3:0] SNAP_YEAR_SUB = 4'd0;
   localparam logic [3:0] SNAP_YEAR_DIV = 4'd1;
   localparam logic [3:0] SNAP_YEAR_MOD = 4'd2;
   localparam logic [3:0] SNAP_FIRST_WR = 4'd3;
   localparam logic [3:0] SNAP_LAST     = 4'd9;

   // time register indexes
   localparam logic [2:0] TREG_SECOND  = 3'd0;
   localparam logic [2:0] TREG_MINUTE  = 3'd1;
   localparam logic [2:0] TREG_HOUR    = 3'd2;
   localparam logic [2:0] TREG_WEEKDAY = 3'd3;
   localparam logic [2:0] TREG_DAY     = 3'd4;
   localparam logic [2:0] TREG_MONTH   = 3'd5;
   localparam logic [2:0] TREG_YEAR    = 3'd6;

   localparam logic [11:0] YEAR_CENTURY_MAX = 12'd99;
   localparam logic [10:0] YEAR_RECIP_100   = 11'd1311;   // 2^17 / 100

   typedef struct packed {
      logic       capture;
      logic       exec;
      logic       snap_en;
      logic [3:0] snap_step;
      logic       clear_en;
      logic [7:0] clear_addr;
   } ctrl_cmd_type;

   typedef struct packed {
      logic snap_req;
   } ctrl_sts_type;

   // BCD of a value below 100; tens by reciprocal multiply
   function automatic logic [7:0] to_bcd(input logic [6:0] v);
      logic [13:0] p;
      logic [3:0]  tens;
      logic [6:0]  ones;
      p    = 14'(v) * 14'd103;
      tens = p[13:10];
      ones = v - 7'({3'b000, tens} * 7'd10);
      return {tens, ones[3:0]};
   endfunction

   // v mod 19 for an 8-bit v; quotient by 27/512
   function automatic logic [7:0] mod19(input logic [7:0] v);
      logic [12:0] p;
      logic [3:0]  q;
      p = 13'(v) * 13'd27;
      q = p[12:9];
      return v - 8'({4'b0000, q} * 8'd19);
   endfunction

endpackage

>>> design/irs_channels.sv
// Request and response channel interfaces of the RTC register slave.
// Depends on nothing.
interface irs_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [7:0]  bus_address;
   logic [7:0]  data_byte;
   logic [5:0]  second;
   logic [5:0]  minute;
   logic [4:0]  hour;
   logic [2:0]  weekday;
   logic [4:0]  day_of_month;
   logic [3:0]  month_index;
   logic [11:0] calendar_year;

   modport source (output valid, mode, bus_address, data_byte, second, minute, hour,
                   weekday, day_of_month, month_index, calendar_year, input ready);
   modport sink   (input valid, mode, bus_address, data_byte, second, minute, hour,
                   weekday, day_of_month, month_index, calendar_year, output ready);
endinterface

interface irs_rsp_if;
   logic       valid;
   logic       ready;
   logic       status;
   logic [7:0] read_data;

   modport source (output valid, status, read_data, input ready);
   modport sink   (input valid, status, read_data, output ready);
endinterface

>>> design/irs_ctrl.sv
// Controller FSM: clearing pass, accept, execute, snapshot sequence.
// Depends on irs_pkg.
module irs_ctrl #(
   parameter int STORE_DEPTH = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  irs_pkg::ctrl_sts_type  sts,
   output irs_pkg::ctrl_cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_CLEAR = 2'd0,
      ST_IDLE  = 2'd1,
      ST_EXEC  = 2'd2,
      ST_SNAP  = 2'd3
   } state_type;

   localparam logic [7:0] CLEAR_LAST = 8'(STORE_DEPTH - 1);

   state_type  state_ff;
   logic [7:0] clear_cnt_ff;
   logic [3:0] snap_step_ff;
   logic       rsp_valid_ff;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd            = '0;
      cmd.capture    = (state_ff == ST_IDLE) && req_valid;
      cmd.exec       = (state_ff == ST_EXEC) && out_free;
      cmd.snap_en    = (state_ff == ST_SNAP);
      cmd.snap_step  = snap_step_ff;
      cmd.clear_en   = (state_ff == ST_CLEAR);
      cmd.clear_addr = clear_cnt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_cnt_ff <= '0;
         snap_step_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.exec) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_CLEAR: begin
               clear_cnt_ff <= clear_cnt_ff + 8'd1;
               if (clear_cnt_ff == CLEAR_LAST) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               if (out_free) begin
                  snap_step_ff <= irs_pkg::SNAP_YEAR_SUB;
                  state_ff     <= sts.snap_req ? ST_SNAP : ST_IDLE;
               end
            end
            ST_SNAP: begin
               snap_step_ff <= snap_step_ff + 4'd1;
               if (snap_step_ff == irs_pkg::SNAP_LAST) begin
                  state_ff <= ST_IDLE;
               end
            end
         endcase
      end
   end

endmodule

>>> design/irs_dpath.sv
// Datapath: captured request, bus phase, cursor, config, register store.
// Depends on irs_pkg; driven by irs_ctrl commands.
module irs_dpath #(
   parameter int STORE_DEPTH = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  irs_pkg::ctrl_cmd_type                cmd,
   output irs_pkg::ctrl_sts_type                sts,
   input  logic [1:0]                           req_mode,
   input  logic [7:0]                           req_bus_address,
   input  logic [7:0]                           req_data_byte,
   input  logic [5:0]                           req_second,
   input  logic [5:0]                           req_minute,
   input  logic [4:0]                           req_hour,
   input  logic [2:0]                           req_weekday,
   input  logic [4:0]                           req_day_of_month,
   input  logic [3:0]                           req_month_index,
   input  logic [11:0]                          req_calendar_year,
   input  logic                                 csr_we,
   input  logic [irs_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [irs_pkg::CSR_DATA_W-1:0]       csr_wdata,
   output logic                                 rsp_status,
   output logic [7:0]                           rsp_read_data
);

   localparam int AW = $clog2(STORE_DEPTH);
   localparam logic [9:0] DEPTH_X1 = 10'(STORE_DEPTH);
   localparam logic [9:0] DEPTH_X2 = 10'(2 * STORE_DEPTH);
   localparam logic [7:0] LIM_MAX  = 8'(STORE_DEPTH - 1);

   // 8-bit value mod STORE_DEPTH; value < 4 * STORE_DEPTH
   function automatic logic [AW-1:0] fold_depth(input logic [7:0] v);
      logic [9:0] t;
      t = {2'b00, v};
      if (t >= DEPTH_X2) t = t - DEPTH_X2;
      if (t >= DEPTH_X1) t = t - DEPTH_X1;
      return t[AW-1:0];
   endfunction

   logic [7:0] store_mem [STORE_DEPTH];

   // captured request
   irs_pkg::mode_type mode_ff;
   logic [7:0]  addr_ff;
   logic [7:0]  data_ff;
   logic [5:0]  second_ff;
   logic [5:0]  minute_ff;
   logic [4:0]  hour_ff;
   logic [2:0]  weekday_ff;
   logic [4:0]  day_ff;
   logic [3:0]  month_ff;
   logic [11:0] cal_ff;

   irs_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  cursor_ff, cursor_in;
   logic [1:0]  chip_ff;
   logic [11:0] epoch_ff;
   logic [7:0]  rd_ff;
   logic [11:0] yr_ff;
   logic [5:0]  yq_ff;
   logic [6:0]  ymod_ff;
   logic        century_ff;
   logic        status_ff, status_in;
   logic [7:0]  rdata_ff, rdata_in;

   logic [7:0]    lim_raw, lim;
   logic [8:0]    cursor_inc;
   logic [7:0]    cursor_adv;
   logic [7:0]    cursor_set;
   logic          addr_match;
   logic          wr_store;
   logic [2:0]    treg_idx;
   logic [6:0]    snap_val;
   logic [7:0]    snap_byte;
   logic          snap_wr;
   logic [22:0]   yq_prod;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [7:0]    mem_wdata;

   // limit and cursor arithmetic
   assign lim_raw    = irs_pkg::LIMIT_TABLE[chip_ff];
   assign lim        = (lim_raw > LIM_MAX) ? LIM_MAX : lim_raw;
   assign cursor_inc = {1'b0, cursor_ff} + 9'd1;
   assign cursor_adv = (cursor_inc > {1'b0, lim}) ? 8'd0 : cursor_inc[7:0];

   always_comb begin
      if (chip_ff == irs_pkg::CHIP_BASE) begin
         cursor_set = data_ff & irs_pkg::BASE_MASK;
      end else if (chip_ff == irs_pkg::CHIP_COMPACT) begin
         cursor_set = irs_pkg::mod19(data_ff);
      end else begin
         cursor_set = 8'(fold_depth(data_ff));
      end
   end

   assign addr_match   = (addr_ff[7:1] == irs_pkg::DEV_ADDR);
   assign sts.snap_req = (mode_ff == irs_pkg::MODE_START) && addr_match && addr_ff[0]
                         && (phase_ff != irs_pkg::PH_READ);

   // event execution
   always_comb begin
      phase_in  = phase_ff;
      cursor_in = cursor_ff;
      status_in = 1'b0;
      rdata_in  = 8'd0;
      wr_store  = 1'b0;
      unique case (mode_ff)
         irs_pkg::MODE_START: begin
            if (!addr_match) begin
               status_in = 1'b1;
            end else if (addr_ff[0]) begin
               phase_in = irs_pkg::PH_READ;
            end else begin
               phase_in = irs_pkg::PH_CURSOR;
            end
         end
         irs_pkg::MODE_STOP: begin
            phase_in = irs_pkg::PH_IDLE;
         end
         irs_pkg::MODE_WRITE: begin
            if (phase_ff == irs_pkg::PH_CURSOR) begin
               cursor_in = cursor_set;
               phase_in  = irs_pkg::PH_WRITE;
            end else if (phase_ff == irs_pkg::PH_WRITE) begin
               wr_store  = 1'b1;
               cursor_in = cursor_adv;
            end
         end
         irs_pkg::MODE_READ: begin
            if (phase_ff == irs_pkg::PH_READ) begin
               rdata_in  = rd_ff;
               cursor_in = cursor_adv;
            end else begin
               rdata_in = irs_pkg::READ_IDLE_BYTE;
            end
         end
      endcase
   end

   // snapshot: one BCD register per write step
   assign treg_idx = 3'(cmd.snap_step - irs_pkg::SNAP_FIRST_WR);
   assign snap_wr  = cmd.snap_en && (cmd.snap_step >= irs_pkg::SNAP_FIRST_WR);
   assign yq_prod  = 23'(yr_ff) * 23'(irs_pkg::YEAR_RECIP_100);

   always_comb begin
      unique case (treg_idx)
         irs_pkg::TREG_SECOND:  snap_val = 7'(second_ff);
         irs_pkg::TREG_MINUTE:  snap_val = 7'(minute_ff);
         irs_pkg::TREG_HOUR:    snap_val = 7'(hour_ff);
         irs_pkg::TREG_WEEKDAY: snap_val = 7'(weekday_ff) + 7'd1;
         irs_pkg::TREG_DAY:     snap_val = 7'(day_ff);
         irs_pkg::TREG_MONTH:   snap_val = 7'(month_ff) + 7'd1;
         irs_pkg::TREG_YEAR:    snap_val = ymod_ff;
         default:               snap_val = 7'd0;
      endcase
      snap_byte = irs_pkg::to_bcd(snap_val);
      if (treg_idx == irs_pkg::TREG_MONTH) begin
         snap_byte[7] = century_ff;
      end
   end

   // store write port
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = '0;
      mem_wdata = 8'd0;
      priority if (cmd.clear_en) begin
         mem_we    = 1'b1;
         mem_waddr = cmd.clear_addr[AW-1:0];
      end else if (snap_wr) begin
         mem_we    = 1'b1;
         mem_waddr = AW'(treg_idx);
         mem_wdata = snap_byte;
      end else if (cmd.exec && wr_store) begin
         mem_we    = 1'b1;
         mem_waddr = fold_depth(cursor_ff);
         mem_wdata = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= store_mem[fold_depth(cursor_ff)];
   end

   // payload capture and snapshot year pipeline
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff    <= irs_pkg::mode_type'(req_mode);
         addr_ff    <= req_bus_address;
         data_ff    <= req_data_byte;
         second_ff  <= req_second;
         minute_ff  <= req_minute;
         hour_ff    <= req_hour;
         weekday_ff <= req_weekday;
         day_ff     <= req_day_of_month;
         month_ff   <= req_month_index;
         cal_ff     <= req_calendar_year;
      end
      if (cmd.snap_en && cmd.snap_step == irs_pkg::SNAP_YEAR_SUB) begin
         yr_ff <= (cal_ff >= epoch_ff) ? cal_ff - epoch_ff : 12'd0;
      end
      if (cmd.snap_en && cmd.snap_step == irs_pkg::SNAP_YEAR_DIV) begin
         yq_ff <= yq_prod[22:17];
      end
      if (cmd.snap_en && cmd.snap_step == irs_pkg::SNAP_YEAR_MOD) begin
         ymod_ff    <= 7'(yr_ff - 12'({6'b000000, yq_ff} * 12'd100));
         century_ff <= (yr_ff > irs_pkg::YEAR_CENTURY_MAX);
      end
      if (cmd.exec) begin
         status_ff <= status_in;
         rdata_ff  <= rdata_in;
      end
   end

   // control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= irs_pkg::PH_IDLE;
         cursor_ff <= 8'd0;
         chip_ff   <= irs_pkg::CHIP_TYPE_RESET;
         epoch_ff  <= irs_pkg::EPOCH_YEAR_RESET;
      end else begin
         if (cmd.exec) begin
            phase_ff  <= phase_in;
            cursor_ff <= cursor_in;
         end
         if (csr_we) begin
            if (csr_index == irs_pkg::CSR_CHIP_TYPE) begin
               chip_ff <= csr_wdata[1:0];
            end else if (csr_index == irs_pkg::CSR_EPOCH_YEAR) begin
               epoch_ff <= csr_wdata;
            end
         end
      end
   end

   assign rsp_status    = status_ff;
   assign rsp_read_data = rdata_ff;

endmodule

>>> design/i2c_rtc_register_slave_core.sv
// RTC register slave top level: controller plus datapath.
// Depends on irs_pkg, irs_channels, irs_ctrl, irs_dpath.
//
// Usage:
//  - req_bus carries one bus event per transfer (start with address byte,
//    stop, write byte, read byte) plus the current time fields, which are
//    used only by a read start that takes a snapshot.
//  - rsp_bus returns exactly one transfer per event: status (foreign address)
//    and read_data (store byte, 0xFF outside the read phase, else 0).
//  - csr_* writes chip_type (index 0) and epoch_year (index 1); write only
//    while no event is in flight.
// Timing:
//  - Event accepted in the idle state; the execute state then runs it and
//    loads the response register, which drives rsp valid; no new event is
//    taken until the controller is back in the idle state.
//  - A read start that snapshots the clock adds a snapshot sequence (three year
//    steps, then one store write per time register over the single write port).
//  - After reset a clearing pass zeroes the store, one entry per cycle, with
//    req ready low until it ends.
//  - A stalled rsp sink holds the next event in execute until the response
//    register frees; ready stays low meanwhile.
module i2c_rtc_register_slave_core #(
   parameter int STORE_DEPTH = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   irs_req_if.sink                           req_bus,
   irs_rsp_if.source                         rsp_bus,
   input  logic                              csr_we,
   input  logic [irs_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [irs_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   irs_pkg::ctrl_cmd_type cmd;
   irs_pkg::ctrl_sts_type sts;

   // sequencer: clear pass, accept, execute, snapshot steps
   irs_ctrl #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // phase, cursor, config registers and register store
   irs_dpath #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_mode          (req_bus.mode),
      .req_bus_address   (req_bus.bus_address),
      .req_data_byte     (req_bus.data_byte),
      .req_second        (req_bus.second),
      .req_minute        (req_bus.minute),
      .req_hour          (req_bus.hour),
      .req_weekday       (req_bus.weekday),
      .req_day_of_month  (req_bus.day_of_month),
      .req_month_index   (req_bus.month_index),
      .req_calendar_year (req_bus.calendar_year),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_status        (rsp_bus.status),
      .rsp_read_data     (rsp_bus.read_data)
   );

endmodule

>>> design/irs_checker.sv
// Port-level checks for the RTC register slave, bound to the top level.
// Depends on i2c_rtc_register_slave_core_assert.svh.
`include "i2c_rtc_register_slave_core_assert.svh"

module irs_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_status,
   input logic [7:0] rsp_read_data
);

   logic       rsp_wait;
   logic [8:0] rsp_payload;
   logic       take_free;

   assign rsp_wait    = rsp_valid && !rsp_ready;
   assign rsp_payload = {rsp_status, rsp_read_data};
   // accept while the response register is empty or draining
   assign take_free   = req_valid && req_ready && (!rsp_valid || rsp_ready);

   `IRS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait, rsp_valid)
   `IRS_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_wait, $stable(rsp_payload))
   // one event at a time: no accept in the cycle after an accept
   `IRS_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready)
   // with the response register free at accept, rsp valid follows once execute loads it
   `IRS_ASSERT_SAME(a_rsp_after_accept, clock, reset, $past(take_free, 2), rsp_valid)

endmodule

bind i2c_rtc_register_slave_core irs_checker u_irs_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_status    (rsp_bus.status),
   .rsp_read_data (rsp_bus.read_data)
);

>>> tb/i2c_rtc_register_slave_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the RTC register slave core: directed bus events,
// then random transfers under several chip/epoch settings with flow control.
// Depends on irs_pkg, irs_channels and the core RTL.
module i2c_rtc_register_slave_core_tb;

   localparam int STORE_DEPTH = 256;
   localparam int PHASE_ITEMS = 220;        // random events per config phase
   localparam int QUIET_CYCLES = 16;        // covers snapshot latency before csr writes
   localparam logic [7:0] ADDR_WR = {irs_pkg::DEV_ADDR, 1'b0};
   localparam logic [7:0] ADDR_RD = {irs_pkg::DEV_ADDR, 1'b1};
   // chip types without a package name
   localparam logic [1:0] CHIP_WIDE  = 2'd2;
   localparam logic [1:0] CHIP_SPARE = 2'd3;

   typedef struct packed {
      irs_pkg::mode_type mode;
      logic [7:0]  bus_address;
      logic [7:0]  data_byte;
      logic [5:0]  second;
      logic [5:0]  minute;
      logic [4:0]  hour;
      logic [2:0]  weekday;
      logic [4:0]  day_of_month;
      logic [3:0]  month_index;
      logic [11:0] calendar_year;
   } bus_event_type;

   typedef struct packed {
      logic       status;
      logic [7:0] read_data;
   } reply_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [irs_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [irs_pkg::CSR_DATA_W-1:0]  csr_wdata;

   irs_req_if req_bus ();
   irs_rsp_if rsp_bus ();

   i2c_rtc_register_slave_core #(
      .STORE_DEPTH(STORE_DEPTH)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the slave: register file, cursor, bus phase, config.
   logic [7:0] shadow_regs [STORE_DEPTH];
   logic [7:0] shadow_cursor;
   irs_pkg::phase_type shadow_phase;
   logic [1:0] cfg_chip;
   logic [11:0] cfg_epoch;

   reply_type pending_replies [$];
   reply_type head_reply;

   // run bookkeeping
   int error_count = 0;
   int events_sent = 0;
   int replies_checked = 0;
   int snapshots_taken = 0;
   int foreign_starts = 0;
   int csr_writes = 0;

   // sender burst state; req_up mirrors what has been driven on valid
   bit req_up = 1'b0;
   bit sender_idle = 1'b1;
   int burst_left = 1;

   // receiver stall pattern and long hold-off, owned by the receiver process
   bit rsp_stall_on = 1'b1;
   bit rsp_on = 1'b1;
   int run_left = 0;
   int hold_left = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard stop in case the core hangs.
   initial begin
      #4_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // cursor wrap point for the current chip type, clamped to the store size
   function automatic int cursor_limit();
      int lim;
      case (cfg_chip)
         irs_pkg::CHIP_BASE:    lim = 63;
         irs_pkg::CHIP_COMPACT: lim = 18;
         default:               lim = 255;  // wide and spare types share the full range
      endcase
      return (lim > STORE_DEPTH - 1) ? STORE_DEPTH - 1 : lim;
   endfunction

   function automatic logic [7:0] bcd_byte(int v);
      int r;
      r = v % 100;
      return {4'(r / 10), 4'(r % 10)};
   endfunction

   // a cursor left past the limit by a chip-type change wraps to 0 here
   function automatic void advance_cursor();
      int nxt;
      nxt = int'(shadow_cursor) + 1;
      shadow_cursor = (nxt > cursor_limit()) ? 8'd0 : 8'(nxt);
   endfunction

   // Applies one accepted bus event to the shadow state; returns the reply.
   function automatic reply_type apply_bus_event(bus_event_type ev);
      reply_type r;
      int lim;
      int yr;
      logic [7:0] mon;
      r.status = 1'b0;
      r.read_data = 8'h00;
      case (ev.mode)
         irs_pkg::MODE_START: begin
            if (ev.bus_address[7:1] != irs_pkg::DEV_ADDR) begin
               // foreign device: nothing moves
               r.status = 1'b1;
               foreign_starts++;
            end else if (ev.bus_address[0]) begin
               // repeated read start keeps the earlier snapshot
               if (shadow_phase != irs_pkg::PH_READ) begin
                  yr = (ev.calendar_year >= cfg_epoch) ?
                       int'(ev.calendar_year) - int'(cfg_epoch) : 0;
                  shadow_regs[irs_pkg::TREG_SECOND]  = bcd_byte(int'(ev.second));
                  shadow_regs[irs_pkg::TREG_MINUTE]  = bcd_byte(int'(ev.minute));
                  shadow_regs[irs_pkg::TREG_HOUR]    = bcd_byte(int'(ev.hour));
                  shadow_regs[irs_pkg::TREG_WEEKDAY] = bcd_byte(int'(ev.weekday) + 1);
                  shadow_regs[irs_pkg::TREG_DAY]     = bcd_byte(int'(ev.day_of_month));
                  mon = bcd_byte(int'(ev.month_index) + 1);
                  if (yr > 99) mon[7] = 1'b1;   // century flag
                  shadow_regs[irs_pkg::TREG_MONTH]   = mon;
                  shadow_regs[irs_pkg::TREG_YEAR]    = bcd_byte(yr % 100);
                  snapshots_taken++;
               end
               shadow_phase = irs_pkg::PH_READ;
            end else begin
               shadow_phase = irs_pkg::PH_CURSOR;
            end
         end
         irs_pkg::MODE_STOP: shadow_phase = irs_pkg::PH_IDLE;
         irs_pkg::MODE_WRITE: begin
            if (shadow_phase == irs_pkg::PH_CURSOR) begin
               lim = cursor_limit();
               shadow_cursor = (int'(ev.data_byte) <= lim) ? ev.data_byte :
                               8'(int'(ev.data_byte) % (lim + 1));
               shadow_phase = irs_pkg::PH_WRITE;
            end else if (shadow_phase == irs_pkg::PH_WRITE) begin
               shadow_regs[shadow_cursor] = ev.data_byte;
               advance_cursor();
            end
            // idle or read phase: write is dropped
         end
         default: begin
            if (shadow_phase == irs_pkg::PH_READ) begin
               r.read_data = shadow_regs[shadow_cursor];
               advance_cursor();
            end else begin
               r.read_data = irs_pkg::READ_IDLE_BYTE;
            end
         end
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Response checking
   // ---------------------------------------------------------------------

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH @%0t %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      error_count++;
   endtask

   // every response transfer is matched against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_replies.size() == 0) begin
            report_mismatch("response with nothing pending", rsp_bus.read_data, 0);
         end else begin
            head_reply = pending_replies.pop_front();
            replies_checked++;
            if (rsp_bus.status !== head_reply.status)
               report_mismatch("status", rsp_bus.status, head_reply.status);
            if (rsp_bus.read_data !== head_reply.read_data)
               report_mismatch("read_data", rsp_bus.read_data, head_reply.read_data);
         end
      end
   end

   // Receiver: a long hold-off when requested, else alternating ready/stall
   // runs of random length, or always ready while stalls are switched off.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left--;
      end else if (!rsp_stall_on) begin
         rsp_bus.ready <= 1'b1;
      end else begin
         if (run_left == 0) begin
            rsp_on = !rsp_on;
            run_left = rsp_on ? $urandom_range(1, 24) : $urandom_range(1, 7);
         end else begin
            run_left--;
         end
         rsp_bus.ready <= rsp_on;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Fills the time fields at random: half in calendar range, half over the
   // full field width; the year mostly lands around the current epoch.
   function automatic bus_event_type compose_event(irs_pkg::mode_type m,
                                                   logic [7:0] a, logic [7:0] d);
      bus_event_type ev;
      int yr;
      int offs;
      ev.mode = m;
      ev.bus_address = a;
      ev.data_byte = d;
      if ($urandom_range(0, 1)) begin
         ev.second       = 6'($urandom_range(0, 60));
         ev.minute       = 6'($urandom_range(0, 59));
         ev.hour         = 5'($urandom_range(0, 23));
         ev.weekday      = 3'($urandom_range(0, 6));
         ev.day_of_month = 5'($urandom_range(1, 31));
         ev.month_index  = 4'($urandom_range(0, 11));
      end else begin
         ev.second       = 6'($urandom);
         ev.minute       = 6'($urandom);
         ev.hour         = 5'($urandom);
         ev.weekday      = 3'($urandom);
         ev.day_of_month = 5'($urandom);
         ev.month_index  = 4'($urandom);
      end
      offs = $urandom_range(0, 220);
      if ($urandom_range(0, 3) == 0) yr = $urandom_range(0, 4095);
      else yr = int'(cfg_epoch) + offs - 20;
      if (yr < 0) yr = 0;
      if (yr > 4095) yr = 4095;
      ev.calendar_year = 12'(yr);
      return ev;
   endfunction

   // One request transfer; prediction is taken at the accepting edge.
   task automatic send_event(input bus_event_type ev);
      reply_type want;
      if (!req_up) begin
         req_bus.valid <= 1'b1;
         req_up = 1'b1;
      end
      req_bus.mode          <= ev.mode;
      req_bus.bus_address   <= ev.bus_address;
      req_bus.data_byte     <= ev.data_byte;
      req_bus.second        <= ev.second;
      req_bus.minute        <= ev.minute;
      req_bus.hour          <= ev.hour;
      req_bus.weekday       <= ev.weekday;
      req_bus.day_of_month  <= ev.day_of_month;
      req_bus.month_index   <= ev.month_index;
      req_bus.calendar_year <= ev.calendar_year;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      want = apply_bus_event(ev);
      pending_replies.push_back(want);
      events_sent++;
      // burst bookkeeping: gap only at the end of a burst
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if (sender_idle) begin
            req_bus.valid <= 1'b0;
            req_up = 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   endtask

   task automatic do_start(input logic [7:0] a);
      send_event(compose_event(irs_pkg::MODE_START, a, 8'($urandom)));
   endtask

   task automatic do_stop();
      send_event(compose_event(irs_pkg::MODE_STOP, 8'($urandom), 8'($urandom)));
   endtask

   task automatic do_write(input logic [7:0] d);
      send_event(compose_event(irs_pkg::MODE_WRITE, 8'($urandom), d));
   endtask

   task automatic do_read();
      send_event(compose_event(irs_pkg::MODE_READ, 8'($urandom), 8'($urandom)));
   endtask

   // drop valid, drain all responses, then let any snapshot work finish
   task automatic wait_bus_quiet();
      if (req_up) begin
         req_bus.valid <= 1'b0;
         req_up = 1'b0;
      end
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [irs_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [irs_pkg::CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx == irs_pkg::CSR_CHIP_TYPE) cfg_chip = val[1:0];
      else cfg_epoch = val;
      csr_writes++;
   endtask

   // cursor byte: mostly inside the current limit, sometimes anywhere
   function automatic logic [7:0] pick_cursor_byte();
      if ($urandom_range(0, 3) == 0) return 8'($urandom);
      return 8'($urandom_range(0, cursor_limit()));
   endfunction

   // One random bus sequence: mostly well-formed transfers with random
   // content, the rest noise and broken sequences.
   task automatic random_transfer();
      int kind;
      int n;
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
         // write transfer: pointer byte then data, stop usually present
         do_start(ADDR_WR);
         do_write(pick_cursor_byte());
         n = $urandom_range(0, 8);
         repeat (n) do_write(8'($urandom));
         if ($urandom_range(0, 5) != 0) do_stop();
      end else if (kind < 75) begin
         // optional pointer set, then a read transfer
         if ($urandom_range(0, 2) != 0) begin
            do_start(ADDR_WR);
            do_write(pick_cursor_byte());
            if ($urandom_range(0, 1)) do_stop();
         end
         do_start(ADDR_RD);
         n = $urandom_range(1, 10);
         repeat (n) do_read();
         if ($urandom_range(0, 4) == 0) begin
            do_start(ADDR_RD);     // repeated read start, no fresh snapshot
            do_read();
         end
         if ($urandom_range(0, 5) != 0) do_stop();
      end else if (kind < 88) begin
         // raw noise over every mode
         n = $urandom_range(1, 4);
         repeat (n)
            send_event(compose_event(irs_pkg::mode_type'($urandom_range(0, 3)),
                                     8'($urandom), 8'($urandom)));
      end else begin
         // near-miss address (one address bit flipped) then stray traffic
         if ($urandom_range(0, 1)) do_start(ADDR_WR ^ (8'h01 << $urandom_range(1, 7)));
         else do_start(ADDR_RD ^ (8'h01 << $urandom_range(1, 7)));
         n = $urandom_range(1, 3);
         repeat (n) begin
            if ($urandom_range(0, 1)) do_read();
            else do_write(8'($urandom));
         end
         if ($urandom_range(0, 1)) do_stop();
      end
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // reads and writes outside any transfer, plus a foreign address
   task automatic test_idle_events();
      do_read();
      do_write(8'hA5);
      do_start(8'hFF);
   endtask

   // out-of-range pointer byte, wrap at the limit, snapshot with all time
   // fields at maximum and a year before the epoch, repeated read start
   task automatic test_write_read_path();
      bus_event_type ev;
      do_start(ADDR_WR);
      do_write(8'hFF);
      do_write(8'hA5);
      do_write(8'h5A);
      do_stop();
      ev = compose_event(irs_pkg::MODE_START, ADDR_RD, 8'h00);
      ev.second = '1;
      ev.minute = '1;
      ev.hour = '1;
      ev.weekday = '1;
      ev.day_of_month = '1;
      ev.month_index = '1;
      ev.calendar_year = '0;
      send_event(ev);
      do_read();
      ev = compose_event(irs_pkg::MODE_START, ADDR_RD, 8'h00);
      send_event(ev);
      do_read();
      do_write(8'h3C);   // write during read phase is dropped
      do_stop();
   endtask

   // century flag boundary: last year without it, then a large year
   task automatic test_year_encoding();
      bus_event_type ev;
      wait_bus_quiet();
      write_csr(irs_pkg::CSR_EPOCH_YEAR, 12'd1900);
      do_start(ADDR_WR);
      do_write(8'(irs_pkg::TREG_MONTH));
      ev = compose_event(irs_pkg::MODE_START, ADDR_RD, 8'h00);
      ev.calendar_year = 12'd1999;
      send_event(ev);
      do_read();
      do_read();
      do_stop();
      wait_bus_quiet();
      write_csr(irs_pkg::CSR_EPOCH_YEAR, 12'd0);
      do_start(ADDR_WR);
      do_write(8'(irs_pkg::TREG_MONTH));
      ev = compose_event(irs_pkg::MODE_START, ADDR_RD, 8'h00);
      ev.calendar_year = 12'd4095;
      send_event(ev);
      do_read();
      do_read();
      do_stop();
   endtask

   // chip type shrinks mid-transfer: the cursor sits past the new limit
   task automatic test_cursor_past_limit();
      wait_bus_quiet();
      write_csr(irs_pkg::CSR_CHIP_TYPE, irs_pkg::CSR_DATA_W'(CHIP_WIDE));
      do_start(ADDR_WR);
      do_write(8'd200);
      do_write(8'h3C);
      wait_bus_quiet();
      write_csr(irs_pkg::CSR_CHIP_TYPE, irs_pkg::CSR_DATA_W'(irs_pkg::CHIP_COMPACT));
      do_write(8'hC3);
      do_write(8'h77);
      do_stop();
   endtask

   // Random phases, each with its own chip type and epoch. The first four
   // walk through every chip type, two of them with the epoch at an extreme.
   task automatic test_random_phases(input int first, input int last);
      int stop_at;
      logic [1:0] chip;
      logic [11:0] epoch;
      for (int p = first; p < last; p++) begin
         wait_bus_quiet();
         case (p)
            0: begin chip = irs_pkg::CHIP_BASE;    epoch = irs_pkg::EPOCH_YEAR_RESET; end
            1: begin chip = irs_pkg::CHIP_COMPACT; epoch = 12'd0;                     end
            2: begin chip = CHIP_WIDE;             epoch = 12'd4095;                  end
            3: begin chip = CHIP_SPARE;            epoch = 12'd2000;                  end
            default: begin
               chip = 2'($urandom_range(0, 3));
               epoch = 12'($urandom);
            end
         endcase
         write_csr(irs_pkg::CSR_CHIP_TYPE, irs_pkg::CSR_DATA_W'(chip));
         write_csr(irs_pkg::CSR_EPOCH_YEAR, epoch);
         // some phases run without sender gaps or receiver stalls
         sender_idle = (p % 3) != 0;
         rsp_stall_on = (p % 4) != 1;
         stop_at = events_sent + PHASE_ITEMS;
         while (events_sent < stop_at) random_transfer();
      end
   endtask

   // receiver holds off for a long stretch while the sender keeps offering,
   // so the core fills up and stalls its request side
   task automatic test_backpressure();
      bit was_idle;
      was_idle = sender_idle;
      sender_idle = 1'b0;
      hold_left = 300;
      do_start(ADDR_WR);
      do_write(pick_cursor_byte());
      repeat (8) do_write(8'($urandom));
      do_stop();
      do_start(ADDR_RD);
      repeat (4) do_read();
      do_stop();
      sender_idle = was_idle;
   endtask

   initial begin
      for (int i = 0; i < STORE_DEPTH; i++) shadow_regs[i] = 8'h00;
      shadow_cursor = 8'h00;
      shadow_phase = irs_pkg::PH_IDLE;
      cfg_chip = irs_pkg::CHIP_TYPE_RESET;
      cfg_epoch = irs_pkg::EPOCH_YEAR_RESET;

      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      req_bus.valid <= 1'b0;
      req_bus.mode <= irs_pkg::MODE_START;
      req_bus.bus_address <= '0;
      req_bus.data_byte <= '0;
      req_bus.second <= '0;
      req_bus.minute <= '0;
      req_bus.hour <= '0;
      req_bus.weekday <= '0;
      req_bus.day_of_month <= '0;
      req_bus.month_index <= '0;
      req_bus.calendar_year <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // the core clears its store after reset; send_event waits on ready
      test_idle_events();
      test_write_read_path();
      test_year_encoding();
      test_cursor_past_limit();
      test_random_phases(0, 4);
      test_backpressure();
      test_random_phases(4, 8);

      // drain with a bound, then flag anything still outstanding
      if (req_up) begin
         req_bus.valid <= 1'b0;
         req_up = 1'b0;
      end
      for (int i = 0; i < 5000 && pending_replies.size() != 0; i++) @(posedge clock);
      if (pending_replies.size() != 0)
         report_mismatch("responses never returned", 0, pending_replies.size());
      repeat (QUIET_CYCLES) @(posedge clock);

      $display("Ran %0d bus events (%0d time snapshots, %0d foreign starts) over %0d csr writes",
               events_sent, snapshots_taken, foreign_starts, csr_writes);
      $display("Checked %0d responses, %0d mismatches", replies_checked, error_count);
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

>>> sim.f
+incdir+design
design/irs_pkg.sv
design/irs_channels.sv
design/irs_ctrl.sv
design/irs_dpath.sv
design/i2c_rtc_register_slave_core.sv
design/irs_checker.sv
tb/i2c_rtc_register_slave_core_tb.sv
